// ----- rtl/id3_pkg.sv -----
// Shared types and constants for the ID3v2.3 tag frame parser.
package id3_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } id3_req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  text_byte;
      logic [28:0] frame_offset;
      logic [32:0] frame_size;
      logic        finished;
      logic        outcome;
   } id3_rsp_type;

   typedef enum logic [5:0] {
      PH_HEADER   = 6'b000001,
      PH_FRAMEHDR = 6'b000010,
      PH_ENCODING = 6'b000100,
      PH_TEXT     = 6'b001000,
      PH_SKIP     = 6'b010000,
      PH_DONE     = 6'b100000
   } id3_phase_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_TITLE  = 2'd1,
      KIND_ARTIST = 2'd2
   } id3_kind_type;

   localparam logic [2:0] EV_NONE        = 3'd0;
   localparam logic [2:0] EV_TITLE_TEXT  = 3'd1;
   localparam logic [2:0] EV_ARTIST_TEXT = 3'd2;
   localparam logic [2:0] EV_TITLE_FRAME = 3'd3;
   localparam logic [2:0] EV_ARTIST_FRAME = 3'd4;

   localparam logic [31:0] ID_TITLE  = 32'h5449_5432;  // "TIT2"
   localparam logic [31:0] ID_ARTIST = 32'h5450_4531;  // "TPE1"

   localparam logic [15:0] TEXT_LIMIT_RESET = 16'd100;
   localparam int          OFFSET_W = 40;
   localparam int          TAG_HDR_BYTES = 10;
   localparam int          FRAME_HDR_BYTES = 10;

endpackage

// ----- rtl/id3v23_frame_parser.sv -----
// Top level of the streaming ID3v2.3 tag frame parser.
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_ready  one file byte plus end-of-file flag
//   rsp      out        rsp_valid/rsp_ready  one result per accepted byte
//   csr      in         csr_valid/csr_ready  text length limit (16 bits)
//
// One byte is accepted per cycle when not stalled; its result appears in the
// output register on the next cycle. The per-byte work is a set of compares,
// shifts and adds on the parser state. A stalled result register holds off
// req_ready only when it is full and not being taken. Synchronous reset clears
// the parser state and loads the text limit with 100; csr_ready is always high.
module id3v23_frame_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  id3_pkg::id3_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output id3_pkg::id3_rsp_type rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [15:0]          csr_data
);

   id3_pkg::id3_phase_type phase_ff, phase_in;
   id3_pkg::id3_kind_type  frame_kind_ff, frame_kind_in;
   logic [id3_pkg::OFFSET_W-1:0] byte_offset_ff, byte_offset_in;
   logic [28:0] tag_end_ff, tag_end_in;
   logic [31:0] header_shift_ff, header_shift_in;
   logic [31:0] frame_id_shift_ff, frame_id_shift_in;
   logic [28:0] frame_start_ff, frame_start_in;
   logic [32:0] next_frame_at_ff, next_frame_at_in;
   logic [15:0] text_remaining_ff, text_remaining_in;
   logic [3:0]  hdr_count_ff, hdr_count_in;
   logic        header_ok_ff, header_ok_in;
   logic [15:0] text_limit_ff, text_limit_in;
   logic        rsp_valid_ff, rsp_valid_in;
   id3_pkg::id3_rsp_type rsp_data_ff, rsp_data_in;

   logic        accept;
   logic [7:0]  b;
   logic [31:0] size_minus_one;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;
   assign b = req_payload.data_byte;
   assign size_minus_one = header_shift_ff - 32'd1;

   always_comb begin
      text_limit_in = text_limit_ff;
      if (csr_valid) begin
         text_limit_in = csr_data;
      end
   end

   always_comb begin
      phase_in          = phase_ff;
      frame_kind_in     = frame_kind_ff;
      byte_offset_in    = byte_offset_ff;
      tag_end_in        = tag_end_ff;
      header_shift_in   = header_shift_ff;
      frame_id_shift_in = frame_id_shift_ff;
      frame_start_in    = frame_start_ff;
      next_frame_at_in  = next_frame_at_ff;
      text_remaining_in = text_remaining_ff;
      hdr_count_in      = hdr_count_ff;
      header_ok_in      = header_ok_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_data_in       = rsp_data_ff;

      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;

         unique case (phase_ff)
            id3_pkg::PH_HEADER: begin
               if (byte_offset_ff == 40'd0) begin
                  header_ok_in = (b == 8'h49);
               end else if (byte_offset_ff == 40'd1) begin
                  header_ok_in = header_ok_ff && (b == 8'h44);
               end else if (byte_offset_ff == 40'd2) begin
                  header_ok_in = header_ok_ff && (b == 8'h33);
               end else if (byte_offset_ff >= 40'd6) begin
                  header_shift_in = {header_shift_ff[24:0], b[6:0]};
               end
               if (byte_offset_ff >= 40'(id3_pkg::TAG_HDR_BYTES - 1)) begin
                  if (!header_ok_in) begin
                     phase_in = id3_pkg::PH_DONE;
                  end else begin
                     tag_end_in = 29'(id3_pkg::TAG_HDR_BYTES)
                                + {1'b0, header_shift_in[27:0]};
                     next_frame_at_in = 33'(id3_pkg::TAG_HDR_BYTES);
                     phase_in = id3_pkg::PH_SKIP;
                  end
               end
            end
            id3_pkg::PH_SKIP: begin
               if ({7'd0, next_frame_at_ff} == byte_offset_ff) begin
                  // A frame id starting with zero marks the padding area.
                  if (byte_offset_ff >= {11'd0, tag_end_ff} || b == 8'd0) begin
                     phase_in = id3_pkg::PH_DONE;
                  end else begin
                     frame_start_in    = byte_offset_ff[28:0];
                     frame_id_shift_in = {24'd0, b};
                     hdr_count_in      = 4'd1;
                     phase_in          = id3_pkg::PH_FRAMEHDR;
                  end
               end
            end
            id3_pkg::PH_FRAMEHDR: begin
               hdr_count_in = hdr_count_ff + 4'd1;
               if (hdr_count_ff < 4'd4) begin
                  frame_id_shift_in = {frame_id_shift_ff[23:0], b};
               end else if (hdr_count_ff < 4'd8) begin
                  header_shift_in = {header_shift_ff[23:0], b};
               end
               if (hdr_count_ff >= 4'(id3_pkg::FRAME_HDR_BYTES - 1)) begin
                  next_frame_at_in = {4'd0, frame_start_ff}
                                   + 33'(id3_pkg::FRAME_HDR_BYTES)
                                   + {1'b0, header_shift_ff};
                  phase_in = id3_pkg::PH_SKIP;
                  if (frame_id_shift_ff == id3_pkg::ID_TITLE) begin
                     frame_kind_in = id3_pkg::KIND_TITLE;
                  end else if (frame_id_shift_ff == id3_pkg::ID_ARTIST) begin
                     frame_kind_in = id3_pkg::KIND_ARTIST;
                  end else begin
                     frame_kind_in = id3_pkg::KIND_NONE;
                  end
                  if (frame_kind_in != id3_pkg::KIND_NONE) begin
                     rsp_data_in.event_res = (frame_kind_in == id3_pkg::KIND_TITLE)
                                           ? id3_pkg::EV_TITLE_FRAME
                                           : id3_pkg::EV_ARTIST_FRAME;
                     rsp_data_in.frame_offset = frame_start_ff;
                     rsp_data_in.frame_size = {1'b0, header_shift_ff}
                                            + 33'(id3_pkg::FRAME_HDR_BYTES);
                     // Only the low half matters once the length is under the limit.
                     text_remaining_in = size_minus_one[15:0];
                     if (size_minus_one < {16'd0, text_limit_ff}) begin
                        phase_in = id3_pkg::PH_ENCODING;
                     end
                  end
               end
            end
            id3_pkg::PH_ENCODING: begin
               phase_in = (text_remaining_ff != 16'd0) ? id3_pkg::PH_TEXT
                                                       : id3_pkg::PH_SKIP;
            end
            id3_pkg::PH_TEXT: begin
               rsp_data_in.event_res = (frame_kind_ff == id3_pkg::KIND_TITLE)
                                     ? id3_pkg::EV_TITLE_TEXT
                                     : id3_pkg::EV_ARTIST_TEXT;
               rsp_data_in.text_byte = b;
               text_remaining_in = text_remaining_ff - 16'd1;
               if (text_remaining_ff == 16'd1) begin
                  phase_in = id3_pkg::PH_SKIP;
               end
            end
            id3_pkg::PH_DONE: begin
            end
            default: begin
            end
         endcase

         if (byte_offset_ff != '1) begin
            byte_offset_in = byte_offset_ff + 40'd1;
         end

         if (req_payload.last_byte) begin
            rsp_data_in.finished = 1'b1;
            rsp_data_in.outcome  = !(header_ok_in && phase_in != id3_pkg::PH_HEADER);
            phase_in          = id3_pkg::PH_HEADER;
            frame_kind_in     = id3_pkg::KIND_NONE;
            byte_offset_in    = '0;
            tag_end_in        = '0;
            header_shift_in   = '0;
            frame_id_shift_in = '0;
            frame_start_in    = '0;
            next_frame_at_in  = '0;
            text_remaining_in = '0;
            hdr_count_in      = '0;
            header_ok_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= id3_pkg::PH_HEADER;
         frame_kind_ff     <= id3_pkg::KIND_NONE;
         byte_offset_ff    <= '0;
         tag_end_ff        <= '0;
         header_shift_ff   <= '0;
         frame_id_shift_ff <= '0;
         frame_start_ff    <= '0;
         next_frame_at_ff  <= '0;
         text_remaining_ff <= '0;
         hdr_count_ff      <= '0;
         header_ok_ff      <= 1'b0;
         text_limit_ff     <= id3_pkg::TEXT_LIMIT_RESET;
         rsp_valid_ff      <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         frame_kind_ff     <= frame_kind_in;
         byte_offset_ff    <= byte_offset_in;
         tag_end_ff        <= tag_end_in;
         header_shift_ff   <= header_shift_in;
         frame_id_shift_ff <= frame_id_shift_in;
         frame_start_ff    <= frame_start_in;
         next_frame_at_ff  <= next_frame_at_in;
         text_remaining_ff <= text_remaining_in;
         hdr_count_ff      <= hdr_count_in;
         header_ok_ff      <= header_ok_in;
         text_limit_ff     <= text_limit_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
